@@ hdl/bvm_pkg.sv @@
// ----------------------------------------------------------------------------
// bvm_pkg - shared constants for the battery voltage monitor
// opcodes, register indexes and fixed field widths
// ----------------------------------------------------------------------------
package bvm_pkg;

    // field widths fixed by the item format
    localparam int MV_W     = 16;   // millivolt values
    localparam int SUM_W    = 20;   // running window sum
    localparam int CELL_W   = 4;    // cell count
    localparam int OP_W     = 2;
    localparam int CFG_IDX_W = 3;
    localparam int FS_W     = 5;    // filter size register

    // millivolts at full scale of the converter
    localparam int SCALE_MV = 3300;
    localparam int SCALE_W  = 12;   // bits of SCALE_MV
    localparam int Q_FRAC   = 8;    // fraction bits of the divider ratio

    // opcodes
    localparam logic [OP_W-1:0] OP_PRIME  = 2'd0;
    localparam logic [OP_W-1:0] OP_SAMPLE = 2'd1;
    localparam logic [OP_W-1:0] OP_BEGIN  = 2'd2;
    localparam logic [OP_W-1:0] OP_CHECK  = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DIVIDER   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRECISION = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_CELL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_CELL  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DETECT    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_MAX  = 3'd6;

    // register reset values
    localparam logic [MV_W-1:0] RST_DIVIDER   = 16'd256;
    localparam logic [FS_W-1:0] RST_FILTER    = 5'd8;
    localparam logic [MV_W-1:0] RST_PRECISION = 16'd100;
    localparam logic [MV_W-1:0] RST_LOW_CELL  = 16'd3500;
    localparam logic [MV_W-1:0] RST_MIN_CELL  = 16'd3300;
    localparam logic [MV_W-1:0] RST_DETECT    = 16'd3000;
    localparam logic [MV_W-1:0] RST_CELL_MAX  = 16'd4350;

endpackage

@@ hdl/bvm_ram.sv @@
// ----------------------------------------------------------------------------
// bvm_ram - generic single write port ram
// one write and one registered read per cycle
// ----------------------------------------------------------------------------
module bvm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                   i_clk,
    input  logic                   i_we,
    input  logic [ADDR_W-1:0]      i_waddr,
    input  logic [WIDTH-1:0]       i_wdata,
    input  logic                   i_re,
    input  logic [ADDR_W-1:0]      i_raddr,
    output logic [WIDTH-1:0]       o_rdata
);
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/bvm_mult.sv @@
// ----------------------------------------------------------------------------
// bvm_mult - bit-serial unsigned multiplier
// one multiplier bit per cycle, shift-add into a right-shifting accumulator
// ----------------------------------------------------------------------------
module bvm_mult #(
    parameter int A_W = 24,
    parameter int B_W = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [A_W-1:0]     i_a,
    input  logic [B_W-1:0]     i_b,
    output logic               o_done,
    output logic [A_W+B_W-1:0] o_prod
);
    localparam int P_W   = A_W + B_W;
    localparam int CNT_W = $clog2(B_W + 1);

    logic [A_W-1:0]   r_a;
    logic [P_W-1:0]   r_acc;
    logic [CNT_W-1:0] r_cnt;
    logic             r_done;
    logic [A_W:0]     add_sum;
    logic [P_W:0]     shifted;

    // upper bits plus multiplicand when the current multiplier bit is set
    assign add_sum = {1'b0, r_acc[P_W-1:B_W]} + (r_acc[0] ? {1'b0, r_a} : '0);
    assign shifted = {add_sum, r_acc[B_W-1:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CNT_W'(B_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_acc <= {{A_W{1'b0}}, i_b};
        end else if (r_cnt != '0) begin
            r_acc <= shifted[P_W:1];
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

@@ hdl/bvm_div.sv @@
// ----------------------------------------------------------------------------
// bvm_div - bit-serial restoring divider
// one quotient bit per cycle, msb first
// ----------------------------------------------------------------------------
module bvm_div #(
    parameter int N_W = 21,
    parameter int D_W = 5
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [N_W-1:0] i_num,
    input  logic [D_W-1:0] i_den,
    output logic           o_done,
    output logic [N_W-1:0] o_quo
);
    localparam int CNT_W = $clog2(N_W + 1);

    logic [D_W-1:0]   r_den;
    logic [D_W-1:0]   r_rem;
    logic [N_W-1:0]   r_quo;
    logic [CNT_W-1:0] r_cnt;
    logic             r_done;
    logic [D_W+1:0]   trial;
    logic             borrow;

    // shift in the next dividend bit and try to take the divisor off
    assign trial  = {1'b0, r_rem, r_quo[N_W-1]} - {2'b00, r_den};
    assign borrow = trial[D_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CNT_W'(N_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_den;
            r_rem <= '0;
            r_quo <= i_num;
        end else if (r_cnt != '0) begin
            if (!borrow) begin
                r_rem <= trial[D_W-1:0];
            end else begin
                r_rem <= {r_rem[D_W-2:0], r_quo[N_W-1]};
            end
            r_quo <= {r_quo[N_W-2:0], ~borrow};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

@@ hdl/battery_voltage_monitor_top.sv @@
// ----------------------------------------------------------------------------
// battery_voltage_monitor_top - battery voltage monitor with window average
// scales adc codes to millivolts, averages over a sample ring, counts cells
// and reports voltage changes, one result transaction per input transaction
// ----------------------------------------------------------------------------
//
//  channel   | direction | signals                        | content
//  ----------+-----------+--------------------------------+---------------------------
//  s_axis    | in        | tvalid tready tdata tuser      | adc_code, opcode
//  m_axis    | out       | tvalid tready tdata            | voltage, flags, cells, limits
//  cfg       | in        | i_cfg_valid o_cfg_ready idx dat| register writes, always ready
//
//  one item at a time: a change check runs only the limit step, a prime
//  the bit-serial scaling multiply, cell detection the cell steps and a
//  filtered sample the scaling multiply and the serial divider. a finished
//  result sits in the output register while the next transaction is taken.
//  synchronous active-low reset clears all control state; the sample ring
//  holds no reset value. a stalled m_axis only blocks once the next result
//  is ready to be loaded.
//
module battery_voltage_monitor_top #(
    parameter int RING_DEPTH = 16,
    parameter int ADC_BITS   = 12,
    parameter int MAX_CELLS  = 15
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [IN_TDATA_W-1:0]              s_axis_tdata,   // adc_code
    input  logic [bvm_pkg::OP_W-1:0]           s_axis_tuser,   // opcode
    // result stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // voltage_mv, changed, cell_count, cells_found, low_limit_mv, min_limit_mv
    output logic [OUT_TDATA_W-1:0]             m_axis_tdata,
    // configuration writes
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [bvm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [bvm_pkg::MV_W-1:0]           i_cfg_data
);
    localparam int IN_TDATA_W  = ((ADC_BITS + 7) / 8) * 8;
    localparam int OUT_FIELD_W = 3 * bvm_pkg::MV_W + bvm_pkg::CELL_W + 2;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    localparam int MV_W   = bvm_pkg::MV_W;
    localparam int SUM_W  = bvm_pkg::SUM_W;
    localparam int CELL_W = bvm_pkg::CELL_W;
    localparam int FS_W   = bvm_pkg::FS_W;

    // ring indexing
    localparam int SLOT_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int SIZE_W = $clog2(RING_DEPTH + 1);
    localparam int EXT_W  = (SIZE_W > FS_W) ? SIZE_W : FS_W;
    localparam int DEN_W  = $clog2(RING_DEPTH + 2);

    // scaling product widths
    localparam int K_W    = ADC_BITS + bvm_pkg::SCALE_W;
    localparam int P_W    = K_W + MV_W;
    localparam int RAW_W  = P_W - ADC_BITS - bvm_pkg::Q_FRAC;
    localparam int NUM_W  = SUM_W + 1;
    localparam int CACC_W = MV_W + 1;
    localparam int LACC_W = MV_W + CELL_W;
    localparam int LSTEP_W = $clog2(CELL_W);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_MUL   = 6'b000010,
        S_DIV   = 6'b000100,
        S_CELL  = 6'b001000,
        S_LIMIT = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    t_state                    r_state, n_state;
    logic [bvm_pkg::OP_W-1:0]  r_op, n_op;

    logic [MV_W-1:0]   r_divider, r_precision, r_low_cell, r_min_cell;
    logic [MV_W-1:0]   r_detect, r_cell_max;
    logic [FS_W-1:0]   r_filter;

    logic [SUM_W-1:0]  r_sum, n_sum;
    logic [SLOT_W-1:0] r_ring_slot, n_ring_slot;
    logic [SLOT_W-1:0] r_prime_slot, n_prime_slot;
    logic [MV_W-1:0]   r_cur, n_cur;
    logic [MV_W-1:0]   r_prev, n_prev;
    logic [CELL_W-1:0] r_cells, n_cells;
    logic              r_changed, n_changed;
    logic [MV_W-1:0]   r_v, n_v;
    logic [CACC_W-1:0] r_cacc, n_cacc;
    logic [CELL_W-1:0] r_cn, n_cn;
    logic [LSTEP_W-1:0] r_lstep, n_lstep;
    logic [LACC_W-1:0] r_low_acc, n_low_acc;
    logic [LACC_W-1:0] r_min_acc, n_min_acc;
    logic              r_m_valid, n_m_valid;
    logic [OUT_TDATA_W-1:0] r_m_data, n_m_data;

    // ------------------------------------------------------------------
    // datapath wiring
    // ------------------------------------------------------------------
    logic              accept;
    logic [EXT_W-1:0]  fs_ext, size_ext;
    logic [SIZE_W-1:0] size;
    logic [SLOT_W-1:0] ring_eff, prime_eff, ring_adv, prime_adv;
    logic [SIZE_W-1:0] ring_inc, prime_inc;

    logic              mul_start, mul_done;
    logic [K_W-1:0]    mul_a;
    logic [P_W-1:0]    mul_prod;
    logic [RAW_W-1:0]  v_raw;
    logic [MV_W-1:0]   v_mv;

    logic              div_start, div_done;
    logic [NUM_W-1:0]  div_num, div_quo;
    logic [DEN_W-1:0]  div_den;
    logic [MV_W-1:0]   avg_mv;

    logic              ram_we, ram_re;
    logic [SLOT_W-1:0] ram_waddr, ram_raddr;
    logic [MV_W-1:0]   ram_wdata, ram_rdata;

    logic [MV_W-1:0]   diff_mv;
    logic [MV_W-1:0]   low_out, min_out;
    logic              out_load;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;

    // filter sizes above the ring depth act as the ring depth
    assign fs_ext   = EXT_W'(r_filter);
    assign size_ext = (fs_ext > EXT_W'(RING_DEPTH)) ? EXT_W'(RING_DEPTH) : fs_ext;
    assign size     = size_ext[SIZE_W-1:0];

    // slots left beyond the window after a size change restart at zero
    assign ring_eff  = (SIZE_W'(r_ring_slot) >= size) ? '0 : r_ring_slot;
    assign prime_eff = (SIZE_W'(r_prime_slot) >= size) ? '0 : r_prime_slot;
    assign ring_inc  = SIZE_W'(ring_eff) + 1'b1;
    assign prime_inc = SIZE_W'(prime_eff) + 1'b1;
    assign ring_adv  = (ring_inc >= size) ? '0 : ring_inc[SLOT_W-1:0];
    assign prime_adv = (prime_inc >= size) ? '0 : prime_inc[SLOT_W-1:0];

    // code times full-scale millivolts, then serially times the divider ratio
    assign mul_a     = K_W'(s_axis_tdata[ADC_BITS-1:0]) * K_W'(bvm_pkg::SCALE_MV);
    assign mul_start = accept && (s_axis_tuser == bvm_pkg::OP_PRIME ||
                                  s_axis_tuser == bvm_pkg::OP_SAMPLE);

    bvm_mult #(
        .A_W (K_W),
        .B_W (MV_W)
    ) u_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (r_divider),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    // drop the adc and q8.8 fraction bits, saturate to 16 bits
    assign v_raw = mul_prod[P_W-1:ADC_BITS+bvm_pkg::Q_FRAC];
    assign v_mv  = (|v_raw[RAW_W-1:MV_W]) ? '1 : v_raw[MV_W-1:0];

    // window average: new sample plus stored sum over size plus one
    assign div_num   = NUM_W'(v_mv) + NUM_W'(r_sum);
    assign div_den   = DEN_W'(size) + 1'b1;
    assign div_start = (r_state == S_MUL) && mul_done &&
                       (r_op == bvm_pkg::OP_SAMPLE) && (size != '0);

    bvm_div #(
        .N_W (NUM_W),
        .D_W (DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign avg_mv = (|div_quo[NUM_W-1:MV_W]) ? '1 : div_quo[MV_W-1:0];

    bvm_ram #(
        .WIDTH (MV_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // the oldest sample is fetched as the transaction is taken
    assign ram_re    = accept && (s_axis_tuser == bvm_pkg::OP_SAMPLE);
    assign ram_raddr = ring_eff;

    assign diff_mv = (r_cur >= r_prev) ? (r_cur - r_prev) : (r_prev - r_cur);

    // limits: per-cell value while cells is unknown, else saturated product
    assign low_out = (r_cells == '0) ? r_low_cell :
                     ((|r_low_acc[LACC_W-1:MV_W]) ? '1 : r_low_acc[MV_W-1:0]);
    assign min_out = (r_cells == '0) ? r_min_cell :
                     ((|r_min_acc[LACC_W-1:MV_W]) ? '1 : r_min_acc[MV_W-1:0]);

    assign out_load = (r_state == S_OUT) && (!r_m_valid || m_axis_tready);

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_sum        = r_sum;
        n_ring_slot  = r_ring_slot;
        n_prime_slot = r_prime_slot;
        n_cur        = r_cur;
        n_prev       = r_prev;
        n_cells      = r_cells;
        n_changed    = r_changed;
        n_v          = r_v;
        n_cacc       = r_cacc;
        n_cn         = r_cn;
        n_lstep      = r_lstep;
        n_low_acc    = r_low_acc;
        n_min_acc    = r_min_acc;
        ram_we       = 1'b0;
        ram_waddr    = ring_eff;
        ram_wdata    = r_v;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_op      = s_axis_tuser;
                    n_changed = 1'b0;
                    n_lstep   = LSTEP_W'(CELL_W - 1);
                    n_low_acc = '0;
                    n_min_acc = '0;
                    unique case (s_axis_tuser)
                        bvm_pkg::OP_PRIME, bvm_pkg::OP_SAMPLE: begin
                            n_state = S_MUL;
                        end
                        bvm_pkg::OP_BEGIN: begin
                            n_state = S_LIMIT;
                            // detection runs only while the cell count is unknown
                            if (r_cells == '0) begin
                                n_prev = r_cur;
                                if (r_cur >= r_detect && r_cur != '0) begin
                                    n_cacc  = '0;
                                    n_cn    = '0;
                                    n_state = S_CELL;
                                end
                            end
                        end
                        bvm_pkg::OP_CHECK: begin
                            n_changed = (diff_mv >= r_precision);
                            n_prev    = r_cur;
                            n_state   = S_LIMIT;
                        end
                        default: begin
                            n_state = S_LIMIT;
                        end
                    endcase
                end
            end
            S_MUL: begin
                if (mul_done) begin
                    n_v = v_mv;
                    if (r_op == bvm_pkg::OP_PRIME) begin
                        if (size != '0) begin
                            // slot zero starts a new priming round
                            ram_we       = 1'b1;
                            ram_waddr    = prime_eff;
                            ram_wdata    = v_mv;
                            n_prime_slot = prime_adv;
                            if (prime_eff == '0) begin
                                n_sum       = SUM_W'(v_mv);
                                n_ring_slot = '0;
                            end else begin
                                n_sum = r_sum + SUM_W'(v_mv);
                            end
                        end
                        n_cur   = v_mv;
                        n_prev  = v_mv;
                        n_state = S_LIMIT;
                    end else if (size == '0) begin
                        n_cur   = v_mv;
                        n_state = S_LIMIT;
                    end else begin
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (div_done) begin
                    // replace the oldest sample, sum wraps at its width
                    n_cur       = avg_mv;
                    ram_we      = 1'b1;
                    ram_waddr   = ring_eff;
                    ram_wdata   = r_v;
                    n_sum       = r_sum + SUM_W'(r_v) - SUM_W'(ram_rdata);
                    n_ring_slot = ring_adv;
                    n_state     = S_LIMIT;
                end
            end
            S_CELL: begin
                // step one cell voltage at a time until the total covers it or MAX_CELLS
                if (r_cacc >= CACC_W'(r_cur) || r_cn == CELL_W'(MAX_CELLS)) begin
                    n_cells = r_cn;
                    n_state = S_LIMIT;
                end else begin
                    n_cacc = r_cacc + CACC_W'(r_cell_max);
                    n_cn   = r_cn + 1'b1;
                end
            end
            S_LIMIT: begin
                // msb-first shift-add of the per-cell values by the cell count
                n_low_acc = {r_low_acc[LACC_W-2:0], 1'b0} +
                            (r_cells[r_lstep] ? LACC_W'(r_low_cell) : '0);
                n_min_acc = {r_min_acc[LACC_W-2:0], 1'b0} +
                            (r_cells[r_lstep] ? LACC_W'(r_min_cell) : '0);
                if (r_lstep == '0) begin
                    n_state = S_OUT;
                end else begin
                    n_lstep = r_lstep - 1'b1;
                end
            end
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output register, refilled as soon as the previous result is taken
    always_comb begin
        n_m_valid = r_m_valid;
        n_m_data  = r_m_data;
        if (out_load) begin
            n_m_valid = 1'b1;
            n_m_data  = OUT_TDATA_W'({min_out, low_out, (r_cells != '0), r_cells,
                                      r_changed, r_cur});
        end else if (m_axis_tready) begin
            n_m_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_op         <= bvm_pkg::OP_PRIME;
            r_sum        <= '0;
            r_ring_slot  <= '0;
            r_prime_slot <= '0;
            r_cur        <= '0;
            r_prev       <= '0;
            r_cells      <= '0;
            r_changed    <= 1'b0;
            r_cn         <= '0;
            r_lstep      <= '0;
            r_m_valid    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_op         <= n_op;
            r_sum        <= n_sum;
            r_ring_slot  <= n_ring_slot;
            r_prime_slot <= n_prime_slot;
            r_cur        <= n_cur;
            r_prev       <= n_prev;
            r_cells      <= n_cells;
            r_changed    <= n_changed;
            r_cn         <= n_cn;
            r_lstep      <= n_lstep;
            r_m_valid    <= n_m_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_v       <= n_v;
        r_cacc    <= n_cacc;
        r_low_acc <= n_low_acc;
        r_min_acc <= n_min_acc;
        r_m_data  <= n_m_data;
    end

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_divider   <= bvm_pkg::RST_DIVIDER;
            r_filter    <= bvm_pkg::RST_FILTER;
            r_precision <= bvm_pkg::RST_PRECISION;
            r_low_cell  <= bvm_pkg::RST_LOW_CELL;
            r_min_cell  <= bvm_pkg::RST_MIN_CELL;
            r_detect    <= bvm_pkg::RST_DETECT;
            r_cell_max  <= bvm_pkg::RST_CELL_MAX;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                bvm_pkg::CFG_DIVIDER:   r_divider   <= i_cfg_data;
                bvm_pkg::CFG_FILTER:    r_filter    <= i_cfg_data[FS_W-1:0];
                bvm_pkg::CFG_PRECISION: r_precision <= i_cfg_data;
                bvm_pkg::CFG_LOW_CELL:  r_low_cell  <= i_cfg_data;
                bvm_pkg::CFG_MIN_CELL:  r_min_cell  <= i_cfg_data;
                bvm_pkg::CFG_DETECT:    r_detect    <= i_cfg_data;
                bvm_pkg::CFG_CELL_MAX:  r_cell_max  <= i_cfg_data;
                default: begin
                    // unmapped index, write ignored
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

endmodule
